/* design/priority_handoff_mutex_assert.svh */
// assertion macros for the priority handoff mutex
`ifndef PRIORITY_HANDOFF_MUTEX_ASSERT_SVH
`define PRIORITY_HANDOFF_MUTEX_ASSERT_SVH
`ifndef SYNTHESIS
`define PHM_ASSERT_NOW(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |-> (c)) \
		else $error("mutex check failed");
`define PHM_ASSERT_NEXT(lbl, a, c) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (a) |=> (c)) \
		else $error("mutex check failed");
`else
`define PHM_ASSERT_NOW(lbl, a, c)
`define PHM_ASSERT_NEXT(lbl, a, c)
`endif
`endif

/* design/phm_pkg.sv */
package phm_pkg;

	localparam int MAX_WAITERS = 16;
	localparam int TASK_BITS   = 4;
	localparam int PRIO_BITS   = 8;
	localparam int IDX_BITS    = (MAX_WAITERS > 1) ? $clog2(MAX_WAITERS) : 1;
	localparam int CNT_BITS    = $clog2(MAX_WAITERS + 1);

	localparam logic CMD_LOCK   = 1'b0;
	localparam logic CMD_UNLOCK = 1'b1;

	typedef enum logic [2:0] {
		STAT_ACQUIRED  = 3'd0,
		STAT_BLOCKED   = 3'd1,
		STAT_RELEASED  = 3'd2,
		STAT_HANDOFF   = 3'd3,
		STAT_NOT_OWNER = 3'd4,
		STAT_BAD_CTX   = 3'd5,
		STAT_FULL      = 3'd6
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_FIND,
		S_SCAN,
		S_GRANT,
		S_DONE
	} state_t;

	typedef struct packed {
		logic                ins;
		logic [IDX_BITS-1:0] ins_idx;
		logic                rm;
		logic [IDX_BITS-1:0] rm_idx;
		logic [IDX_BITS-1:0] rm_age;
	} store_ctrl_t;

	typedef struct packed {
		logic [CNT_BITS-1:0]    count;
		logic [MAX_WAITERS-1:0] valid;
	} store_stat_t;

	typedef struct packed {
		logic                 valid;
		logic [TASK_BITS-1:0] task_id;
		logic [PRIO_BITS-1:0] prio;
		logic [IDX_BITS-1:0]  age;
	} entry_t;

endpackage

/* design/phm_waiter_store.sv */
module phm_waiter_store (
	input  logic                                clk,
	input  logic                                arst_n,
	input  phm_pkg::store_ctrl_t                ctrl,
	input  logic [phm_pkg::TASK_BITS-1:0]       wr_task,
	input  logic [phm_pkg::PRIO_BITS-1:0]       wr_prio,
	input  logic [phm_pkg::IDX_BITS-1:0]        rd_idx,
	output phm_pkg::entry_t                     rd_entry,
	output phm_pkg::store_stat_t                stat
);

	logic [phm_pkg::MAX_WAITERS-1:0] valid_q;
	logic [phm_pkg::CNT_BITS-1:0]    count_q;
	logic [phm_pkg::TASK_BITS-1:0]   task_q [phm_pkg::MAX_WAITERS];
	logic [phm_pkg::PRIO_BITS-1:0]   prio_q [phm_pkg::MAX_WAITERS];
	logic [phm_pkg::IDX_BITS-1:0]    age_q  [phm_pkg::MAX_WAITERS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
		end else if (ctrl.ins) begin
			valid_q[ctrl.ins_idx] <= 1'b1;
			count_q <= count_q + 1'b1;
		end else if (ctrl.rm) begin
			valid_q[ctrl.rm_idx] <= 1'b0;
			count_q <= count_q - 1'b1;
		end
	end

	// new waiter takes the youngest rank, removal closes the gap in the ranks
	always_ff @(posedge clk) begin
		if (ctrl.ins) begin
			task_q[ctrl.ins_idx] <= wr_task;
			prio_q[ctrl.ins_idx] <= wr_prio;
			age_q[ctrl.ins_idx]  <= count_q[phm_pkg::IDX_BITS-1:0];
		end else if (ctrl.rm) begin
			for (int i = 0; i < phm_pkg::MAX_WAITERS; i++) begin
				if (valid_q[i] && age_q[i] > ctrl.rm_age)
					age_q[i] <= age_q[i] - 1'b1;
			end
		end
	end

	always_comb begin
		rd_entry.valid   = valid_q[rd_idx];
		rd_entry.task_id = task_q[rd_idx];
		rd_entry.prio    = prio_q[rd_idx];
		rd_entry.age     = age_q[rd_idx];
		stat.count       = count_q;
		stat.valid       = valid_q;
	end

endmodule

/* design/phm_select.sv */
module phm_select (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           start,
	input  logic                           step,
	input  logic [phm_pkg::IDX_BITS-1:0]   idx,
	input  phm_pkg::entry_t                entry,
	output logic                           best_found,
	output logic [phm_pkg::IDX_BITS-1:0]   best_idx,
	output logic [phm_pkg::TASK_BITS-1:0]  best_task,
	output logic [phm_pkg::IDX_BITS-1:0]   best_age
);

	logic                          found_q;
	logic [phm_pkg::IDX_BITS-1:0]  idx_q;
	logic [phm_pkg::TASK_BITS-1:0] task_q;
	logic [phm_pkg::PRIO_BITS-1:0] prio_q;
	logic [phm_pkg::IDX_BITS-1:0]  age_q;
	logic                          better;

	// priority first, arrival rank breaks a tie
	assign better = entry.valid && (!found_q || ({entry.prio, entry.age} < {prio_q, age_q}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
		end else if (start) begin
			found_q <= 1'b0;
		end else if (step && better) begin
			found_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (step && better) begin
			idx_q  <= idx;
			task_q <= entry.task_id;
			prio_q <= entry.prio;
			age_q  <= entry.age;
		end
	end

	assign best_found = found_q;
	assign best_idx   = idx_q;
	assign best_task  = task_q;
	assign best_age   = age_q;

endmodule

/* design/priority_handoff_mutex.sv */
// priority handoff mutex
// input channel s_*: one lock or unlock request per transaction, s_tuser is the
// command (0 lock, 1 unlock). output channel m_*: exactly one result per request.
// the block works on one request at a time and drops s_tready while busy.
// context errors, grants on a free mutex, a full store, owner errors and releases
// without waiters go from the evaluate state straight to the result; a blocked
// lock searches the waiter slots from slot 0 for the first free one (up to
// MAX_WAITERS-1) and inserts there; a handoff scans all MAX_WAITERS slots through
// one shared priority/rank comparator and then grants the winner.
// s_tready comes back together with the m_tvalid of the result, so a new request
// is taken only after the previous one has finished.
// the next request is taken once the previous one finishes, even while its
// result still sits in the output register; when the receiver stalls, a finished
// result waits until the output register is free.
// reset: mutex free, owner 0, waiter store empty, no result pending; the store
// needs no clearing pass.
module priority_handoff_mutex (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// task_id[3:0], task_priority[11:4], task_present[12], from_interrupt[13]
	input  logic [15:0] s_tdata,
	// command
	input  logic        s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// status[2:0], owner_id[6:3], locked_now[7], woken_valid[8], woken_id[12:9]
	output logic [15:0] m_tdata
);

	`include "priority_handoff_mutex_assert.svh"

	localparam logic [phm_pkg::IDX_BITS-1:0] IDX_LAST = phm_pkg::IDX_BITS'(phm_pkg::MAX_WAITERS - 1);
	localparam logic [phm_pkg::CNT_BITS-1:0] CNT_FULL = phm_pkg::CNT_BITS'(phm_pkg::MAX_WAITERS);

	phm_pkg::state_t state_q, state_d;

	logic                          cmd_q;
	logic [phm_pkg::TASK_BITS-1:0] tid_q;
	logic [phm_pkg::PRIO_BITS-1:0] prio_q;
	logic                          ctx_ok_q;
	logic                          held_q;
	logic [phm_pkg::TASK_BITS-1:0] holder_q;
	logic [phm_pkg::IDX_BITS-1:0]  idx_q;
	phm_pkg::status_t              status_q;
	logic                          woken_q;
	logic                          m_tvalid_q;
	logic [15:0]                   m_tdata_q;

	phm_pkg::store_ctrl_t store_ctrl;
	phm_pkg::store_stat_t store_stat;
	phm_pkg::entry_t      rd_entry;
	logic                 sel_start;
	logic                 sel_step;
	logic                          best_found;
	logic [phm_pkg::IDX_BITS-1:0]  best_idx;
	logic [phm_pkg::TASK_BITS-1:0] best_task;
	logic [phm_pkg::IDX_BITS-1:0]  best_age;

	logic in_xfer, out_free, full, is_owner;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_free = !m_tvalid_q || m_tready;
	assign full     = store_stat.count == CNT_FULL;
	assign is_owner = held_q && (holder_q == tid_q);

	phm_waiter_store u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (store_ctrl),
		.wr_task  (tid_q),
		.wr_prio  (prio_q),
		.rd_idx   (idx_q),
		.rd_entry (rd_entry),
		.stat     (store_stat)
	);

	phm_select u_select (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (sel_start),
		.step       (sel_step),
		.idx        (idx_q),
		.entry      (rd_entry),
		.best_found (best_found),
		.best_idx   (best_idx),
		.best_task  (best_task),
		.best_age   (best_age)
	);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			phm_pkg::S_IDLE: begin
				if (s_tvalid)
					state_d = phm_pkg::S_EVAL;
			end
			phm_pkg::S_EVAL: begin
				state_d = phm_pkg::S_DONE;
				if (ctx_ok_q) begin
					if (cmd_q == phm_pkg::CMD_LOCK) begin
						if (held_q && !full)
							state_d = phm_pkg::S_FIND;
					end else if (is_owner && store_stat.count != '0) begin
						state_d = phm_pkg::S_SCAN;
					end
				end
			end
			phm_pkg::S_FIND: begin
				if (!rd_entry.valid)
					state_d = phm_pkg::S_DONE;
			end
			phm_pkg::S_SCAN: begin
				if (idx_q == IDX_LAST)
					state_d = phm_pkg::S_GRANT;
			end
			phm_pkg::S_GRANT: begin
				state_d = phm_pkg::S_DONE;
			end
			phm_pkg::S_DONE: begin
				if (out_free)
					state_d = phm_pkg::S_IDLE;
			end
			default: state_d = phm_pkg::S_IDLE;
		endcase
	end

	// control outputs
	always_comb begin
		s_tready           = state_q == phm_pkg::S_IDLE;
		store_ctrl.ins     = (state_q == phm_pkg::S_FIND) && !rd_entry.valid;
		store_ctrl.ins_idx = idx_q;
		store_ctrl.rm      = state_q == phm_pkg::S_GRANT;
		store_ctrl.rm_idx  = best_idx;
		store_ctrl.rm_age  = best_age;
		sel_start          = state_q == phm_pkg::S_EVAL;
		sel_step           = state_q == phm_pkg::S_SCAN;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= phm_pkg::S_IDLE;
			held_q     <= 1'b0;
			holder_q   <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				phm_pkg::S_EVAL: begin
					if (ctx_ok_q && cmd_q == phm_pkg::CMD_LOCK && !held_q) begin
						held_q   <= 1'b1;
						holder_q <= tid_q;
					end else if (ctx_ok_q && cmd_q == phm_pkg::CMD_UNLOCK && is_owner &&
						store_stat.count == '0) begin
						held_q   <= 1'b0;
						holder_q <= '0;
					end
				end
				phm_pkg::S_GRANT: begin
					holder_q <= best_task;
				end
				default: ;
			endcase
			if (state_q == phm_pkg::S_DONE && out_free)
				m_tvalid_q <= 1'b1;
			else if (m_tready)
				m_tvalid_q <= 1'b0;
		end
	end

	// transaction payload and per-request results
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			cmd_q    <= s_tuser;
			tid_q    <= s_tdata[3:0];
			prio_q   <= s_tdata[11:4];
			ctx_ok_q <= s_tdata[12] && !s_tdata[13];
		end
		case (state_q)
			phm_pkg::S_EVAL: begin
				idx_q   <= '0;
				woken_q <= 1'b0;
				if (!ctx_ok_q)
					status_q <= phm_pkg::STAT_BAD_CTX;
				else if (cmd_q == phm_pkg::CMD_LOCK)
					status_q <= !held_q ? phm_pkg::STAT_ACQUIRED :
						(full ? phm_pkg::STAT_FULL : phm_pkg::STAT_BLOCKED);
				else if (!is_owner)
					status_q <= phm_pkg::STAT_NOT_OWNER;
				else
					status_q <= (store_stat.count == '0) ? phm_pkg::STAT_RELEASED :
						phm_pkg::STAT_HANDOFF;
			end
			phm_pkg::S_FIND, phm_pkg::S_SCAN: begin
				idx_q <= idx_q + 1'b1;
			end
			phm_pkg::S_GRANT: begin
				woken_q <= 1'b1;
			end
			phm_pkg::S_DONE: begin
				if (out_free) begin
					m_tdata_q[2:0]   <= status_q;
					m_tdata_q[6:3]   <= holder_q;
					m_tdata_q[7]     <= held_q;
					m_tdata_q[8]     <= woken_q;
					m_tdata_q[12:9]  <= woken_q ? holder_q : '0;
					m_tdata_q[15:13] <= '0;
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	`PHM_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
	`PHM_ASSERT_NOW(a_count_matches, 1'b1, store_stat.count == $countones(store_stat.valid))
	`PHM_ASSERT_NOW(a_grant_has_winner, state_q == phm_pkg::S_GRANT, best_found)
	`PHM_ASSERT_NOW(a_woken_is_handoff, m_tvalid && m_tdata[8],
		m_tdata[2:0] == phm_pkg::STAT_HANDOFF && m_tdata[7])

endmodule
